### sv/cbwg_pkg.sv
// Shared widths, fixed-point constants and control types for the cubic
// B-spline weight/gradient pipeline. No dependencies.
`default_nettype none

package cbwg_pkg;

    // Fraction bits of the offsets, weights and gradients
    localparam int FRAC_BITS = 16;

    // Fixed port widths
    localparam int DIFF_W    = 20;
    localparam int WEIGHT_W  = 16;
    localparam int GRAD_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int INV_FRAC  = 16;   // fraction bits of the inverse cell size

    // Internal widths
    localparam int U_W    = FRAC_BITS + 1;      // |x| or 2-|x|, at most 1.0
    localparam int N_W    = FRAC_BITS;          // N peaks near 2/3, below 1.0
    localparam int DMAG_W = FRAC_BITS + 1;      // |dN| stays below 1.0
    localparam int NUM_W  = FRAC_BITS + 3;      // numerator of the divide by 6
    localparam int MAG_W  = (FRAC_BITS + 2 > DIFF_W) ? FRAC_BITS + 2 : DIFF_W;
    localparam int G1_W   = FRAC_BITS + 1;      // dN * N before scaling
    localparam int M_W    = G1_W + CFG_W - INV_FRAC;
    localparam int WSAT_W = (N_W > WEIGHT_W) ? N_W : WEIGHT_W;
    localparam int SAT_W  = (M_W > GRAD_W + 1) ? M_W : GRAD_W + 1;

    // Divide by 6 as multiply by reciprocal: floor(v*M6 >> DIV6_SH) == v/6
    // for every v below 8.0, since the reciprocal error times v stays under 2^DIV6_SH.
    localparam int DIV6_SH    = FRAC_BITS + 6;
    localparam int DIV6_MUL_W = DIV6_SH - 1;
    localparam logic [DIV6_MUL_W-1:0] DIV6_MUL =
        DIV6_MUL_W'(((64'd1 << DIV6_SH) + 64'd5) / 64'd6);

    // Pipeline depth: five stages per axis kernel, three combine stages
    localparam int KERN_STAGES = 5;
    localparam int COMB_STAGES = 3;
    localparam int NUM_STAGES  = KERN_STAGES + COMB_STAGES;

    // Per-stage load enables
    typedef struct packed {
        logic [COMB_STAGES-1:0] comb;
        logic [KERN_STAGES-1:0] kern;
    } stage_en_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_X = 1'b0,
        REG_INV_Y = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

### sv/cubic_bspline_weight_gradient.sv
// Top level of the cubic B-spline weight and gradient block for 2-D particle
// transfers. Depends on cbwg_pkg, cbwg_axis_kernel and cbwg_grad_combine.
//
// Usage:
//   - Input channel (in_valid/in_ready) carries one request: the offset
//     diff_x, diff_y from grid node to particle, signed Q4.16.
//   - Output channel (out_valid/out_ready) returns weight_out (Q0.16) and
//     grad_x, grad_y (signed Q16.16, saturated) for each request, in order.
//   - Config port: cfg_we writes cfg_data into register cfg_index
//     (0 = inverse cell width, 1 = inverse cell height, unsigned Q16.16).
//     Write only while no request is in flight.
//   - Pipeline: eight register stages, five in the per-axis kernel and
//     three in combine.
//   - Throughput: one request per cycle while out_ready does not stall the
//     output, set by the fully pipelined kernel and combine multipliers.
//   - Receiver stall: each stage advances when it is empty or the stage
//     after it advances, so bubbles collapse and up to eight requests are
//     held; in_ready drops only when all stages are full and out is stalled.
//   - Reset: pipeline empties and both inverse cell sizes return to 1.0.
`default_nettype none

module cubic_bspline_weight_gradient
    import cbwg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DIFF_W-1:0] diff_x,
    input  wire logic signed [DIFF_W-1:0] diff_y,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [WEIGHT_W-1:0]           weight_out,
    output logic signed [GRAD_W-1:0]      grad_x,
    output logic signed [GRAD_W-1:0]      grad_y,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data
);

    localparam logic [CFG_W-1:0] INV_RESET = CFG_W'(1) << INV_FRAC;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    stage_en_t             stage_en;
    logic [CFG_W-1:0]      inv_x_reg;
    logic [CFG_W-1:0]      inv_y_reg;
    logic [N_W-1:0]        nx;
    logic [N_W-1:0]        ny;
    logic [DMAG_W-1:0]     dmag_x;
    logic [DMAG_W-1:0]     dmag_y;
    logic                  pos_x;
    logic                  pos_y;

    // Stage load enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
            valid_next[0] = in_valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (load[i])
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign stage_en.kern = load[KERN_STAGES-1:0];
    assign stage_en.comb = load[NUM_STAGES-1:KERN_STAGES];

    // Configuration register decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg <= INV_RESET;
            inv_y_reg <= INV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INV_X: inv_x_reg <= cfg_data;
                REG_INV_Y: inv_y_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Per-axis kernels
    cbwg_axis_kernel u_kern_x (
        .clk      (clk),
        .stage_en (stage_en),
        .diff     (diff_x),
        .n        (nx),
        .dmag     (dmag_x),
        .pos      (pos_x)
    );

    cbwg_axis_kernel u_kern_y (
        .clk      (clk),
        .stage_en (stage_en),
        .diff     (diff_y),
        .n        (ny),
        .dmag     (dmag_y),
        .pos      (pos_y)
    );

    // Weight and gradient
    cbwg_grad_combine u_comb (
        .clk      (clk),
        .stage_en (stage_en),
        .nx       (nx),
        .ny       (ny),
        .dmag_x   (dmag_x),
        .dmag_y   (dmag_y),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .inv_x    (inv_x_reg),
        .inv_y    (inv_y_reg),
        .weight   (weight_out),
        .gx       (grad_x),
        .gy       (grad_y)
    );

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

### sv/cbwg_axis_kernel.sv
// One-axis cubic B-spline kernel: N(x) and |dN(x)| over five register stages.
// Depends on cbwg_pkg.
`default_nettype none

module cbwg_axis_kernel
    import cbwg_pkg::*;
(
    input  wire logic                     clk,
    input  wire stage_en_t                stage_en,
    input  wire logic signed [DIFF_W-1:0] diff,
    output logic [N_W-1:0]                n,
    output logic [DMAG_W-1:0]             dmag,
    output logic                          pos
);

    localparam logic [MAG_W-1:0]   ONE_M  = MAG_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0]   TWO_M  = MAG_W'(1) << (FRAC_BITS + 1);
    localparam logic [2*U_W-1:0]   HALF_P = (2*U_W)'(1) << (FRAC_BITS - 1);
    localparam logic [NUM_W-1:0]   FOUR_N = NUM_W'(1) << (FRAC_BITS + 2);

    // Stage 0 signals
    logic [DIFF_W-1:0] raw;
    logic              neg;
    logic [DIFF_W-1:0] mag;
    logic [MAG_W-1:0]  mag_ext;
    logic [MAG_W-1:0]  tail_ext;
    logic [U_W-1:0]    s0_u_reg;
    logic              s0_near_reg;
    logic              s0_far_reg;
    logic              s0_pos_reg;

    // Stage 1/2 signals
    logic [2*U_W-1:0]  sq_full;
    logic [2*U_W-1:0]  cube_full;
    logic [U_W-1:0]    s1_u_reg;
    logic [U_W-1:0]    s1_u2_reg;
    logic              s1_near_reg;
    logic              s1_far_reg;
    logic              s1_pos_reg;
    logic [U_W-1:0]    s2_u_reg;
    logic [U_W-1:0]    s2_u2_reg;
    logic [U_W-1:0]    s2_u3_reg;
    logic              s2_near_reg;
    logic              s2_far_reg;
    logic              s2_pos_reg;

    // Stage 3 signals
    logic [NUM_W-1:0]  hi;
    logic [NUM_W-1:0]  lo;
    logic [NUM_W-1:0]  dhi;
    logic [NUM_W-1:0]  dlo;
    logic [NUM_W-1:0]  ddiff;
    logic [U_W:0]      dtail;
    logic [NUM_W-1:0]  s3_num_next;
    logic [DMAG_W-1:0] s3_dmag_next;
    logic [NUM_W-1:0]  s3_num_reg;
    logic [DMAG_W-1:0] s3_dmag_reg;
    logic              s3_pos_reg;

    // Stage 4 signals
    logic [NUM_W+DIV6_MUL_W-1:0] div_prod;
    logic [N_W-1:0]    s4_n_reg;
    logic [DMAG_W-1:0] s4_dmag_reg;
    logic              s4_pos_reg;

    // Magnitude, range and the variable the polynomials run on
    assign raw      = diff;
    assign neg      = raw[DIFF_W-1];
    assign mag      = neg ? DIFF_W'(~raw + DIFF_W'(1)) : raw;
    assign mag_ext  = MAG_W'(mag);
    assign tail_ext = TWO_M - mag_ext;

    always_ff @(posedge clk)
    begin
        if (stage_en.kern[0])
        begin
            s0_near_reg <= (mag_ext < ONE_M);
            s0_far_reg  <= (mag_ext >= TWO_M);
            s0_u_reg    <= (mag_ext < ONE_M) ? mag_ext[U_W-1:0] : tail_ext[U_W-1:0];
            s0_pos_reg  <= !neg && (mag != '0);
        end
    end

    // Square, rounded to nearest
    assign sq_full = {{U_W{1'b0}}, s0_u_reg} * {{U_W{1'b0}}, s0_u_reg} + HALF_P;

    always_ff @(posedge clk)
    begin
        if (stage_en.kern[1])
        begin
            s1_u_reg    <= s0_u_reg;
            s1_u2_reg   <= sq_full[FRAC_BITS +: U_W];
            s1_near_reg <= s0_near_reg;
            s1_far_reg  <= s0_far_reg;
            s1_pos_reg  <= s0_pos_reg;
        end
    end

    // Cube, rounded to nearest
    assign cube_full = {{U_W{1'b0}}, s1_u2_reg} * {{U_W{1'b0}}, s1_u_reg} + HALF_P;

    always_ff @(posedge clk)
    begin
        if (stage_en.kern[2])
        begin
            s2_u_reg    <= s1_u_reg;
            s2_u2_reg   <= s1_u2_reg;
            s2_u3_reg   <= cube_full[FRAC_BITS +: U_W];
            s2_near_reg <= s1_near_reg;
            s2_far_reg  <= s1_far_reg;
            s2_pos_reg  <= s1_pos_reg;
        end
    end

    // Polynomial numerators and |dN| per segment
    always_comb
    begin
        hi    = NUM_W'(s2_u3_reg) * NUM_W'(3) + FOUR_N;
        lo    = NUM_W'(s2_u2_reg) * NUM_W'(6);
        dhi   = NUM_W'(s2_u_reg) << 2;
        dlo   = NUM_W'(s2_u2_reg) * NUM_W'(3);
        ddiff = dhi - dlo + NUM_W'(1);
        dtail = (U_W+1)'(s2_u2_reg) + (U_W+1)'(1);
        if (s2_far_reg)
        begin
            s3_num_next  = '0;
            s3_dmag_next = '0;
        end
        else if (s2_near_reg)
        begin
            s3_num_next  = (hi > lo) ? (hi - lo + NUM_W'(3)) : '0;
            s3_dmag_next = (dhi > dlo) ? ddiff[DMAG_W:1] : '0;
        end
        else
        begin
            s3_num_next  = NUM_W'(s2_u3_reg) + NUM_W'(3);
            s3_dmag_next = dtail[DMAG_W:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.kern[3])
        begin
            s3_num_reg  <= s3_num_next;
            s3_dmag_reg <= s3_dmag_next;
            s3_pos_reg  <= s2_pos_reg;
        end
    end

    // Divide by 6 through the reciprocal
    assign div_prod = (NUM_W+DIV6_MUL_W)'(s3_num_reg) * (NUM_W+DIV6_MUL_W)'(DIV6_MUL);

    always_ff @(posedge clk)
    begin
        if (stage_en.kern[4])
        begin
            s4_n_reg    <= div_prod[DIV6_SH +: N_W];
            s4_dmag_reg <= s3_dmag_reg;
            s4_pos_reg  <= s3_pos_reg;
        end
    end

    assign n    = s4_n_reg;
    assign dmag = s4_dmag_reg;
    assign pos  = s4_pos_reg;

endmodule

`default_nettype wire

### sv/cbwg_grad_combine.sv
// Combines both axis kernels into weight and scaled, saturated gradient over
// three register stages. Depends on cbwg_pkg.
`default_nettype none

module cbwg_grad_combine
    import cbwg_pkg::*;
(
    input  wire logic                  clk,
    input  wire stage_en_t             stage_en,
    input  wire logic [N_W-1:0]        nx,
    input  wire logic [N_W-1:0]        ny,
    input  wire logic [DMAG_W-1:0]     dmag_x,
    input  wire logic [DMAG_W-1:0]     dmag_y,
    input  wire logic                  pos_x,
    input  wire logic                  pos_y,
    input  wire logic [CFG_W-1:0]      inv_x,
    input  wire logic [CFG_W-1:0]      inv_y,
    output logic [WEIGHT_W-1:0]        weight,
    output logic signed [GRAD_W-1:0]   gx,
    output logic signed [GRAD_W-1:0]   gy
);

    localparam int WP_W = 2 * N_W;
    localparam int GP_W = DMAG_W + N_W;
    localparam int SP_W = G1_W + CFG_W;

    localparam logic [WP_W-1:0] HALF_W = WP_W'(1) << (FRAC_BITS - 1);
    localparam logic [GP_W-1:0] HALF_G = GP_W'(1) << (FRAC_BITS - 1);
    localparam logic [SP_W-1:0] HALF_S = SP_W'(1) << (INV_FRAC - 1);

    logic [WP_W-1:0]     w_prod;
    logic [WSAT_W-1:0]   w_ext;
    logic [GP_W-1:0]     gx_prod;
    logic [GP_W-1:0]     gy_prod;
    logic [SP_W-1:0]     sx_prod;
    logic [SP_W-1:0]     sy_prod;

    logic [WEIGHT_W-1:0] s5_w_reg;
    logic [G1_W-1:0]     s5_g1x_reg;
    logic [G1_W-1:0]     s5_g1y_reg;
    logic                s5_posx_reg;
    logic                s5_posy_reg;
    logic [WEIGHT_W-1:0] s6_w_reg;
    logic [M_W-1:0]      s6_mx_reg;
    logic [M_W-1:0]      s6_my_reg;
    logic                s6_posx_reg;
    logic                s6_posy_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [GRAD_W-1:0]   gx_reg;
    logic [GRAD_W-1:0]   gy_reg;

    // Sign opposite to the offset; negative side reaches -2^31, positive 2^31-1
    function automatic logic [GRAD_W-1:0] grad_sat(input logic [M_W-1:0] m, input logic pos);
        logic [SAT_W-1:0] m_ext;
        logic [SAT_W-1:0] lim;
        logic [GRAD_W-1:0] mag;
        m_ext = SAT_W'(m);
        if (pos)
            lim = SAT_W'(1) << (GRAD_W - 1);
        else
            lim = (SAT_W'(1) << (GRAD_W - 1)) - SAT_W'(1);
        mag = (m_ext > lim) ? lim[GRAD_W-1:0] : m_ext[GRAD_W-1:0];
        if (pos)
            return GRAD_W'(0) - mag;
        else
            return mag;
    endfunction

    // Weight and unscaled gradient products, rounded to nearest
    assign w_prod  = WP_W'(nx) * WP_W'(ny) + HALF_W;
    assign w_ext   = WSAT_W'(w_prod[FRAC_BITS +: N_W]);
    assign gx_prod = GP_W'(dmag_x) * GP_W'(ny) + HALF_G;
    assign gy_prod = GP_W'(dmag_y) * GP_W'(nx) + HALF_G;

    always_ff @(posedge clk)
    begin
        if (stage_en.comb[0])
        begin
            s5_w_reg    <= (w_ext > WSAT_W'({WEIGHT_W{1'b1}})) ? {WEIGHT_W{1'b1}}
                                                               : w_ext[WEIGHT_W-1:0];
            s5_g1x_reg  <= gx_prod[FRAC_BITS +: G1_W];
            s5_g1y_reg  <= gy_prod[FRAC_BITS +: G1_W];
            s5_posx_reg <= pos_x;
            s5_posy_reg <= pos_y;
        end
    end

    // Scale by inverse cell size, rounded to nearest
    assign sx_prod = SP_W'(s5_g1x_reg) * SP_W'(inv_x) + HALF_S;
    assign sy_prod = SP_W'(s5_g1y_reg) * SP_W'(inv_y) + HALF_S;

    always_ff @(posedge clk)
    begin
        if (stage_en.comb[1])
        begin
            s6_w_reg    <= s5_w_reg;
            s6_mx_reg   <= sx_prod[INV_FRAC +: M_W];
            s6_my_reg   <= sy_prod[INV_FRAC +: M_W];
            s6_posx_reg <= s5_posx_reg;
            s6_posy_reg <= s5_posy_reg;
        end
    end

    // Sign, saturate, output register
    always_ff @(posedge clk)
    begin
        if (stage_en.comb[2])
        begin
            weight_reg <= s6_w_reg;
            gx_reg     <= grad_sat(s6_mx_reg, s6_posx_reg);
            gy_reg     <= grad_sat(s6_my_reg, s6_posy_reg);
        end
    end

    assign weight = weight_reg;
    assign gx     = gx_reg;
    assign gy     = gy_reg;

endmodule

`default_nettype wire

### sv/cbwg_checker.sv
// Port-level checks for cubic_bspline_weight_gradient, bound to the top level.
// Depends on cbwg_pkg.
`default_nettype none

module cbwg_checker
    import cbwg_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [WEIGHT_W-1:0]      weight_out,
    input wire logic signed [GRAD_W-1:0] grad_x,
    input wire logic signed [GRAD_W-1:0] grad_y
);

    localparam int CNT_W = $clog2(NUM_STAGES + 1);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Requests in flight, as seen on the ports
    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
            count_next = count_reg + CNT_W'(1);
        else if (out_acc && !in_acc)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight_out)
                                    && $stable(grad_x) && $stable(grad_y))
        else $error("result changed while stalled");

    // Input backpressure only when the output is stalled
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // No result without a request behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result with no outstanding request");

    // Never more requests in flight than pipeline stages
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_STAGES))
        else $error("too many requests in flight");

endmodule

bind cubic_bspline_weight_gradient cbwg_checker u_cbwg_checker (.*);

`default_nettype wire

### dv/cubic_bspline_weight_gradient_test.sv
// Testbench for cubic_bspline_weight_gradient: streams particle-node offsets
// under random and forced stalls, predicts weight and gradient per request
// and checks every result in order. Depends on cbwg_pkg and the block's RTL.
module cubic_bspline_weight_gradient_test;
    import cbwg_pkg::*;

    localparam logic [63:0] ONE_FX     = 64'd1 << FRAC_BITS;
    localparam int          DRAIN_WAIT = NUM_STAGES + 4;
    localparam int          SPAN       = 147456;   // 2.25 cells in Q4.16

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [GRAD_W-1:0]   gx;
        logic [GRAD_W-1:0]   gy;
    } kernel_result_t;

    typedef struct {
        logic [63:0] n;
        logic [63:0] dmag;
        bit          pos;
    } axis_term_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic                     out_valid;
    logic                     out_ready;
    logic [WEIGHT_W-1:0]      weight_out;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_data;

    // Shadow of the inverse cell sizes, updated when a write lands
    logic [63:0] scale_x;
    logic [63:0] scale_y;

    kernel_result_t pending_results[$];
    kernel_result_t oldest;

    bit steady_run;
    int hold_request;
    int hold_left;
    int fail_count;
    int requests_sent;
    int results_checked;
    int scale_settings;

    cubic_bspline_weight_gradient dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .diff_x     (diff_x),
        .diff_y     (diff_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .weight_out (weight_out),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Product of two magnitudes, rounded to nearest with ties upward
    function automatic logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, int sh);
        return (a * b + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Spline value and derivative magnitude on one axis
    function automatic axis_term_t bspline_axis(logic [DIFF_W-1:0] raw);
        axis_term_t  r;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] t3;
        a = raw[DIFF_W-1] ? ((64'd1 << DIFF_W) - 64'(raw)) : 64'(raw);
        r.pos = !raw[DIFF_W-1] && (a != 0);
        if (a >= 2 * ONE_FX)
        begin
            r.n    = 0;
            r.dmag = 0;
        end
        else if (a < ONE_FX)
        begin
            a2 = round_mul(a, a, FRAC_BITS);
            a3 = round_mul(a2, a, FRAC_BITS);
            hi = 3 * a3 + 4 * ONE_FX;
            lo = 6 * a2;
            r.n = (hi > lo) ? (hi - lo + 3) / 6 : 0;
            hi = 4 * a;
            lo = 3 * a2;
            r.dmag = (hi > lo) ? (hi - lo + 1) / 2 : 0;
        end
        else
        begin
            t  = 2 * ONE_FX - a;
            t2 = round_mul(t, t, FRAC_BITS);
            t3 = round_mul(t2, t, FRAC_BITS);
            r.n    = (t3 + 3) / 6;
            r.dmag = (t2 + 1) / 2;
        end
        return r;
    endfunction

    // Gradient component: opposite sign to the offset, saturated to 32 bits
    function automatic logic [GRAD_W-1:0] scaled_slope(logic [63:0] dmag, logic [63:0] n_other,
                                                       logic [63:0] inv, bit pos);
        logic [63:0] m;
        m = round_mul(round_mul(dmag, n_other, FRAC_BITS), inv, INV_FRAC);
        if (m == 0)
            return '0;
        if (pos)
        begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            return GRAD_W'(64'd0 - m);
        end
        if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
        return m[GRAD_W-1:0];
    endfunction

    function automatic kernel_result_t predict_kernel(logic [DIFF_W-1:0] dx,
                                                      logic [DIFF_W-1:0] dy);
        kernel_result_t r;
        axis_term_t     kx;
        axis_term_t     ky;
        logic [63:0]    w;
        kx = bspline_axis(dx);
        ky = bspline_axis(dy);
        w  = round_mul(kx.n, ky.n, FRAC_BITS);
        r.weight = (w > 64'hFFFF) ? 16'hFFFF : w[WEIGHT_W-1:0];
        r.gx = scaled_slope(kx.dmag, ky.n, scale_x, kx.pos);
        r.gy = scaled_slope(ky.dmag, kx.n, scale_y, ky.pos);
        return r;
    endfunction

    // Offset mostly inside the kernel support, with edges and full range mixed in
    function automatic logic [DIFF_W-1:0] pick_offset();
        int v;
        case ($urandom_range(9))
            6:       v = (int'($urandom_range(4)) - 2) * 65536 + int'($urandom_range(6)) - 3;
            7, 8:    v = int'($urandom);
            9:       v = ($urandom_range(1) != 0) ? 524287 : -524288;
            default: v = int'($urandom_range(2 * SPAN)) - SPAN;
        endcase
        return v[DIFF_W-1:0];
    endfunction

    task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    // Result checker: each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure("unrequested result", '0, {16'd0, weight_out});
            end
            else
            begin
                oldest = pending_results.pop_front();
                results_checked++;
                if (weight_out !== oldest.weight)
                    note_failure("weight_out", {16'd0, oldest.weight}, {16'd0, weight_out});
                if (grad_x !== oldest.gx)
                    note_failure("grad_x", oldest.gx, grad_x);
                if (grad_y !== oldest.gy)
                    note_failure("grad_y", oldest.gy, grad_y);
            end
        end
    end

    // Receiver: random stalls, or a forced hold-off counted here
    initial
    begin
        out_ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= steady_run || ($urandom_range(99) >= 20);
            end
        end
    end

    // One request; leaves in_valid high so back-to-back requests need no bubble
    task automatic send_offset(logic [DIFF_W-1:0] dx, logic [DIFF_W-1:0] dy);
        if (!steady_run && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        diff_x   <= dx;
        diff_y   <= dy;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_kernel(dx, dy));
        requests_sent++;
    endtask

    // Sender pauses until every result is back, then lets the pipe settle
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Both inverse cell sizes, written back to back while idle
    task automatic set_cell_scale(logic [CFG_W-1:0] inv_x, logic [CFG_W-1:0] inv_y);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_INV_X;
        cfg_data  <= inv_x;
        @(posedge clk);
        cfg_index <= REG_INV_Y;
        cfg_data  <= inv_y;
        @(posedge clk);
        cfg_we  <= 1'b0;
        scale_x = 64'(inv_x);
        scale_y = 64'(inv_y);
        scale_settings++;
    endtask

    // Field extremes, segment edges, zero and the most negative offset
    task automatic test_directed_offsets();
        int dir_x [22] = '{0, 1, -1, 65535, -65535, 65536, -65536, 131071, -131071,
                           131072, -131072, 524287, -524288, 32768, -98304, 43691,
                           0, 65536, -524288, 200000, 21845, -1};
        int dir_y [22] = '{0, -1, 1, -65535, 65535, 65536, -65536, -131071, 131071,
                           0, 131072, 524287, -524288, -32768, 98304, 43691,
                           65535, 0, 0, -200000, -21845, 131071};
        logic [31:0] v;
        logic [31:0] u;
        for (int i = 0; i < 22; i++)
        begin
            v = dir_x[i];
            u = dir_y[i];
            send_offset(v[DIFF_W-1:0], u[DIFF_W-1:0]);
        end
    endtask

    // Zero and full-scale inverse cell sizes near the gradient peak
    task automatic test_scale_extremes();
        set_cell_scale('0, '0);
        send_offset(20'sd43691, 20'sd0);
        send_offset(-20'sd43691, 20'sd43691);
        send_offset(20'sd98304, -20'sd32768);
        set_cell_scale('1, '1);
        send_offset(20'sd43691, 20'sd0);
        send_offset(-20'sd43691, -20'sd43691);
        send_offset(20'sd0, 20'sd43691);
        send_offset(20'sd98304, -20'sd98304);
        send_offset(20'sd1, -20'sd1);
    endtask

    // Receiver holds off long enough that the pipeline fills and stalls input
    task automatic test_output_backpressure();
        set_cell_scale(32'h0001_8000, 32'h0000_C000);
        steady_run   = 1'b1;
        hold_request = 80;
        for (int i = 0; i < 40; i++)
            send_offset(pick_offset(), pick_offset());
        wait_for_drain();
        steady_run = 1'b0;
    endtask

    // Full-rate stream with no idling on either side
    task automatic test_full_rate();
        set_cell_scale(32'h0002_0000, 32'h0000_8000);
        steady_run = 1'b1;
        for (int i = 0; i < 100; i++)
            send_offset(pick_offset(), pick_offset());
        wait_for_drain();
        steady_run = 1'b0;
    endtask

    // Random offsets across several cell-size settings
    task automatic test_random_offsets();
        logic [CFG_W-1:0] sx [6];
        logic [CFG_W-1:0] sy [6];
        sx = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0000_0001, $urandom};
        sy = '{32'h0001_0000, 32'hFFFF_FFFF, $urandom, $urandom, 32'h0002_0000,
               $urandom_range(32'h0004_0000)};
        for (int p = 0; p < 6; p++)
        begin
            set_cell_scale(sx[p], sy[p]);
            for (int i = 0; i < 90; i++)
                send_offset(pick_offset(), pick_offset());
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        diff_x    <= '0;
        diff_y    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_INV_X;
        cfg_data  <= '0;
        scale_x = 64'd65536;
        scale_y = 64'd65536;
        steady_run      = 1'b0;
        hold_request    = 0;
        fail_count      = 0;
        requests_sent   = 0;
        results_checked = 0;
        scale_settings  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_offsets();
        test_scale_extremes();
        test_output_backpressure();
        test_full_rate();
        test_random_offsets();
        wait_for_drain();

        $display("Checked %0d of %0d offset requests over %0d cell-size settings,",
                 results_checked, requests_sent, scale_settings + 1);
        $display("with random stalls, a forced output hold-off and a full-rate burst.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20 * 300000);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/cbwg_pkg.sv
sv/cbwg_axis_kernel.sv
sv/cbwg_grad_combine.sv
sv/cubic_bspline_weight_gradient.sv
sv/cbwg_checker.sv
dv/cubic_bspline_weight_gradient_test.sv
